// File: hw/rtl/pspk_pkg.sv
// Package for the power-of-two shelf rectangle packer.
// Holds field widths, payload and internal structs, register indexes and the class function.
// No dependencies.
package pspk_pkg;

  localparam int DIM_W            = 13;
  localparam int POS_W            = 12;
  localparam int AREA_W           = 25;
  localparam int PROD_W           = 2 * DIM_W;
  localparam int MIN_SHELF_HEIGHT = 2;
  localparam int HEIGHT_CLASSES   = 16;
  localparam int CLS_W            = $clog2(HEIGHT_CLASSES);
  localparam int LOG_W            = $clog2(DIM_W + 1) + 1;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;

  localparam logic [DIM_W-1:0]  ATLAS_RESET = DIM_W'(512);
  localparam logic [AREA_W-1:0] AREA_MAX    = {AREA_W{1'b1}};

  // Register indexes (address bit 2 selects the register)
  localparam logic REG_ATLAS_WIDTH  = 1'b0;
  localparam logic REG_ATLAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic              placed;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [AREA_W-1:0] area_used;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] atlas_width;
    logic [DIM_W-1:0] atlas_height;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic              attempt;
    logic [CLS_W-1:0]  cls;
    logic [DIM_W-1:0]  w;
    logic [PROD_W-1:0] area;
  } cmd_t;

  // Smallest k with 2^k >= v
  function automatic logic [LOG_W-1:0] ceil_log2(input logic [DIM_W-1:0] v);
    logic [LOG_W-1:0] k;
    k = LOG_W'(DIM_W);
    for (int i = DIM_W; i >= 0; i--) begin
      if (((DIM_W + 1)'(1) << i) >= {1'b0, v}) begin
        k = LOG_W'(i);
      end
    end
    return k;
  endfunction

endpackage

// File: hw/rtl/pow2_shelf_rect_packer_top.sv
// Top level of the power-of-two shelf rectangle packer.
// Depends on pspk_pkg, pspk_cfg, pspk_front, pspk_cmdq and pspk_back.
//
// Places rectangles into an atlas by shelf packing, one open shelf per
// power-of-two height class (height raised to a minimum of two, then rounded
// up). Requests go in through a queue-like port (push/full) and every
// request yields exactly one result word, in order, on a queue-like port
// (empty/pop): placed flag, position (12-bit wrapped, zero when not placed)
// and the saturating running area total. The block sustains one request per
// clock while the result side keeps popping; that figure is set by the back
// stage, which reads and writes the selected class's shelf entry and the
// strip pointer in the same cycle. An accepted request is first loaded into
// the front register (bounds check, class, width times height), then
// written to the two-word request queue, and then the shelf update runs and
// writes its result word to the two-word result queue. Either side can stall
// without holding up the other until the queues fill. The atlas width and
// height registers sit at byte addresses 0 and 4 of the APB port (reset 512
// each) and are to be changed only while the block is idle; open shelves
// survive a change.
module pow2_shelf_rect_packer_top
  import pspk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              push,
  output logic              full,
  input  in_item_t          in_item,
  // result channel
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_item,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;

  pspk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Classify and register each request
  pspk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  // Hold classified requests until the back stage takes them
  pspk_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head     (cmd_head)
  );

  // Advance the shelf table and queue the result word
  pspk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

// File: hw/rtl/pspk_cfg.sv
// APB-style register file for the atlas size.
// Depends on pspk_pkg.
module pspk_cfg
  import pspk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [DIM_W-1:0] atlas_width_r;
  logic [DIM_W-1:0] atlas_height_r;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_width_r  <= ATLAS_RESET;
      atlas_height_r <= ATLAS_RESET;
    end else if (wr_en) begin
      if (reg_sel == REG_ATLAS_WIDTH) begin
        atlas_width_r <= pwdata[DIM_W-1:0];
      end else begin
        atlas_height_r <= pwdata[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ATLAS_WIDTH:  prdata = APB_DW'(atlas_width_r);
      REG_ATLAS_HEIGHT: prdata = APB_DW'(atlas_height_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.atlas_width  = atlas_width_r;
  assign cfg.atlas_height = atlas_height_r;

endmodule

// File: hw/rtl/pspk_front.sv
// Front stage: accepts requests, checks atlas bounds, picks the height class, forms the area.
// Depends on pspk_pkg.
module pspk_front
  import pspk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic             valid_r;
  logic             valid_nxt;
  cmd_t             cmd_r;
  cmd_t             cmd_nxt;
  logic             take;
  logic [DIM_W-1:0] h_min;
  logic [LOG_W-1:0] cls_full;

  assign full   = valid_r && q_full;
  assign take   = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_cmd  = cmd_r;

  always_comb begin
    h_min    = (in_item.rect_height < DIM_W'(MIN_SHELF_HEIGHT)) ?
               DIM_W'(MIN_SHELF_HEIGHT) : in_item.rect_height;
    cls_full = ceil_log2(h_min);
    cmd_nxt.attempt = (in_item.rect_width <= cfg.atlas_width) &&
                      (in_item.rect_height <= cfg.atlas_height) &&
                      (cls_full < LOG_W'(HEIGHT_CLASSES));
    cmd_nxt.cls  = cls_full[CLS_W-1:0];
    cmd_nxt.w    = in_item.rect_width;
    cmd_nxt.area = PROD_W'(in_item.rect_width) * PROD_W'(in_item.rect_height);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: hw/rtl/pspk_cmdq.sv
// Two-word queue of classified requests between front and back.
// Depends on pspk_pkg.
module pspk_cmdq
  import pspk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t       mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/pspk_back.sv
// Back stage: shelf table lookup and update, area total, two-word result queue.
// Depends on pspk_pkg.
module pspk_back
  import pspk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic              shelf_open_r [HEIGHT_CLASSES];
  logic [DIM_W-1:0]  shelf_x_r    [HEIGHT_CLASSES];
  logic [DIM_W-1:0]  shelf_y_r    [HEIGHT_CLASSES];
  logic [DIM_W-1:0]  next_y_r;
  logic [AREA_W-1:0] area_r;

  logic              cur_open;
  logic [DIM_W-1:0]  cur_x;
  logic [DIM_W-1:0]  cur_y;
  logic [DIM_W:0]    hp;
  logic [DIM_W:0]    strip_end;
  logic              fit_x;
  logic              fit_y;
  logic              use_old;
  logic              open_new;
  logic              ok;
  logic [DIM_W-1:0]  px;
  logic [DIM_W-1:0]  py;
  logic [AREA_W+1:0] area_sum;
  logic [AREA_W-1:0] area_nxt;
  out_item_t         res;

  out_item_t         rq_mem [2];
  logic              rq_wr_r;
  logic              rq_rd_r;
  logic [1:0]        rq_cnt_r;
  logic [1:0]        rq_cnt_nxt;
  logic              do_pop;

  assign cmd_pop = cmd_valid && (rq_cnt_r != 2'd2);
  assign empty   = (rq_cnt_r == 2'd0);
  assign do_pop  = pop && !empty;
  assign out_item = rq_mem[rq_rd_r];

  always_comb begin
    cur_open  = shelf_open_r[cmd.cls];
    cur_x     = shelf_x_r[cmd.cls];
    cur_y     = shelf_y_r[cmd.cls];
    hp        = (DIM_W + 1)'(1) << cmd.cls;
    strip_end = {1'b0, next_y_r} + hp;
    fit_x     = ({1'b0, cur_x} + {1'b0, cmd.w}) <= {1'b0, cfg.atlas_width};
    fit_y     = strip_end <= {1'b0, cfg.atlas_height};
    use_old   = cmd.attempt && cur_open && fit_x;
    open_new  = cmd.attempt && !use_old && fit_y;
    ok        = use_old || open_new;
    px        = open_new ? '0 : cur_x;
    py        = open_new ? next_y_r : cur_y;
    area_sum  = (AREA_W + 2)'(area_r) + (AREA_W + 2)'(cmd.area);
    area_nxt  = (area_sum > (AREA_W + 2)'(AREA_MAX)) ? AREA_MAX : area_sum[AREA_W-1:0];

    res.placed    = ok;
    res.pos_x     = ok ? px[POS_W-1:0] : '0;
    res.pos_y     = ok ? py[POS_W-1:0] : '0;
    res.area_used = ok ? area_nxt : area_r;
  end

  // Shelf state and totals; a failed request leaves everything as is
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HEIGHT_CLASSES; i++) begin
        shelf_open_r[i] <= 1'b0;
        shelf_x_r[i]    <= '0;
        shelf_y_r[i]    <= '0;
      end
      next_y_r <= '0;
      area_r   <= '0;
    end else if (cmd_pop && ok) begin
      shelf_open_r[cmd.cls] <= 1'b1;
      shelf_x_r[cmd.cls]    <= px + cmd.w;
      shelf_y_r[cmd.cls]    <= py;
      area_r                <= area_nxt;
      if (open_new) begin
        next_y_r <= strip_end[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (cmd_pop && !do_pop) begin
      rq_cnt_nxt = rq_cnt_r + 2'd1;
    end else if (do_pop && !cmd_pop) begin
      rq_cnt_nxt = rq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      rq_cnt_r <= rq_cnt_nxt;
      if (cmd_pop) begin
        rq_wr_r <= !rq_wr_r;
      end
      if (do_pop) begin
        rq_rd_r <= !rq_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rq_mem[rq_wr_r] <= res;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for pow2_shelf_rect_packer_top: random and directed rectangle requests, APB atlas
// writes between phases, and an in-order scoreboard that predicts every result word.
// Depends on pspk_pkg and the packer RTL.
module tb_top;
  import pspk_pkg::*;

  // Shelf predictor plus the queue of result words still owed by the block.
  class shelf_scoreboard;
    logic [DIM_W-1:0]  atlas_w;
    logic [DIM_W-1:0]  atlas_h;
    bit                shelf_open [HEIGHT_CLASSES];
    logic [DIM_W-1:0]  shelf_x [HEIGHT_CLASSES];
    logic [DIM_W-1:0]  shelf_y [HEIGHT_CLASSES];
    logic [DIM_W-1:0]  strip_y;
    logic [AREA_W-1:0] area_total;
    out_item_t         owed_q [$];
    int                errors;
    int                placed_cnt;
    int                refused_cnt;

    function new();
      atlas_w = ATLAS_RESET;
      atlas_h = ATLAS_RESET;
      for (int i = 0; i < HEIGHT_CLASSES; i++) begin
        shelf_open[i] = 1'b0;
        shelf_x[i]    = '0;
        shelf_y[i]    = '0;
      end
      strip_y     = '0;
      area_total  = '0;
      errors      = 0;
      placed_cnt  = 0;
      refused_cnt = 0;
    endfunction

    function void set_atlas(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      atlas_w = w;
      atlas_h = h;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Work out the placement of one accepted request and queue its result word.
    function void note_request(in_item_t req);
      int unsigned w, h, hm, cls, hp, sum;
      bit          ok;
      out_item_t   want;
      w    = 32'(req.rect_width);
      h    = 32'(req.rect_height);
      ok   = 1'b0;
      want = '0;
      if (w <= atlas_w && h <= atlas_h) begin
        // raise to the minimum shelf height, then round up to a power of two
        hm  = (h < MIN_SHELF_HEIGHT) ? MIN_SHELF_HEIGHT : h;
        cls = 0;
        while ((32'd1 << cls) < hm) cls++;
        if (cls < HEIGHT_CLASSES) begin
          hp = 32'd1 << cls;
          if (shelf_open[cls] && shelf_x[cls] + w <= atlas_w) begin
            ok = 1'b1;
          end else if (strip_y + hp <= atlas_h) begin
            shelf_open[cls] = 1'b1;
            shelf_x[cls]    = '0;
            shelf_y[cls]    = strip_y;
            strip_y         = DIM_W'(strip_y + hp);
            ok              = 1'b1;
          end
          if (ok) begin
            want.pos_x   = POS_W'(shelf_x[cls]);
            want.pos_y   = POS_W'(shelf_y[cls]);
            shelf_x[cls] = DIM_W'(shelf_x[cls] + w);
            sum          = area_total + w * h;
            area_total   = (sum > AREA_MAX) ? AREA_MAX : AREA_W'(sum);
          end
        end
      end
      want.placed    = ok;
      want.area_used = area_total;
      if (ok) placed_cnt++;
      else refused_cnt++;
      owed_q.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
      end
    endfunction

    // Check one popped word against the oldest owed word.
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t ns: result word with none expected, got placed=%0d x=%0d y=%0d area=%0d",
                 $time, got.placed, got.pos_x, got.pos_y, got.area_used);
        return;
      end
      want = owed_q.pop_front();
      compare_field("placed", 32'(want.placed), 32'(got.placed));
      compare_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
      compare_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
      compare_field("area_used", 32'(want.area_used), 32'(got.area_used));
    endfunction
  endclass

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               push     = 1'b0;
  logic               full;
  in_item_t           in_item  = '0;
  logic               empty;
  logic               pop      = 1'b0;
  out_item_t          out_item;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [APB_AW-1:0]  paddr    = '0;
  logic [APB_DW-1:0]  pwdata   = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  shelf_scoreboard board;

  // Traffic knobs, changed per phase by the stimulus process.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Long receiver hold-off: the stimulus bumps the ticket, the receiver counts it out.
  int hold_ticket   = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  pow2_shelf_rect_packer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: check the word taken at this edge, then decide pop for the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        board.check_result(out_item);
      end
      if (hold_served != hold_ticket) begin
        // start a long hold-off so the queues fill and full rises
        hold_served <= hold_ticket;
        hold_left   <= 250;
        pop         <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request and hold it until the block takes it. push is left high on
  // purpose so back-to-back words never drop it; idle gaps lower it first.
  task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    in_item_t item;
    item.rect_width  = w;
    item.rect_height = h;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full);
    board.note_request(item);
  endtask

  // Drop push, wait for every owed word, then let the pipeline go quiet.
  task automatic settle();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write both atlas registers back to back; psel stays high between the two transfers.
  task automatic program_atlas(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    logic             sel;
    logic [DIM_W-1:0] value;
    for (int i = 0; i < 2; i++) begin
      sel     = (i == 0) ? REG_ATLAS_WIDTH : REG_ATLAS_HEIGHT;
      value   = (i == 0) ? w : h;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= APB_DW'(value);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_atlas(w, h);
  endtask

  task automatic reconfigure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    program_atlas(w, h);
  endtask

  // Mostly well-formed rectangles sized to the current atlas, with some
  // oversized and full-range noise mixed in.
  task automatic random_burst(input int count, input int idle, input int stall,
                              input bit long_hold, input bit drain_pauses);
    logic [DIM_W-1:0] w, h;
    int unsigned      roll, k, aw;
    send_idle_pct = idle;
    stall_pct     = stall;
    if (long_hold) hold_ticket <= hold_ticket + 1;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      aw   = 32'(board.atlas_w);
      if (roll < 10) begin
        w = DIM_W'($urandom_range(8191));
        h = DIM_W'($urandom_range(8191));
      end else if (roll < 22) begin
        w = DIM_W'($urandom_range(4096));
        h = DIM_W'($urandom_range(4096));
      end else begin
        k = (roll < 30) ? $urandom_range(12, 8) : $urandom_range(7, 0);
        h = (k == 0) ? DIM_W'($urandom_range(1)) :
                       DIM_W'($urandom_range((1 << k) / 2 + 1, 1 << k));
        w = $urandom_range(1) ? DIM_W'($urandom_range(aw)) :
                                DIM_W'($urandom_range(aw / 8 + 1));
      end
      send_rect(w, h);
      // hold the sender until the block has answered everything
      if (drain_pauses && (i % 20) == 19) settle();
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset atlas of 512 x 512.
    send_rect(13'd0, 13'd0);        // zero size: raised to the minimum class
    send_rect(13'd1, 13'd1);        // small height shares the minimum class
    send_rect(13'd512, 13'd512);    // full atlas: strip no longer fits
    send_rect(13'd513, 13'd1);      // too wide
    send_rect(13'd1, 13'd513);      // too tall
    send_rect(13'd3, 13'd3);
    send_rect(13'd5, 13'd5);
    send_rect(13'd7, 13'd17);
    send_rect(13'd100, 13'd2);
    send_rect(13'd500, 13'd2);      // shelf full across: opens a new one
    send_rect(13'd0, 13'd2);        // zero width: x does not advance
    send_rect(13'd8191, 13'd8191);
    send_rect(13'd4096, 13'd4096);
    send_rect(13'd512, 13'd1);
    send_rect(13'd256, 13'd256);
    send_rect(13'd256, 13'd200);
    send_rect(13'd1, 13'd256);

    // Back to back, with one long hold-off on the result side.
    reconfigure(13'd64, 13'd1024);
    random_burst(90, 0, 0, 1'b1, 1'b0);

    // Sparse input, with drain pauses.
    reconfigure(13'd4096, 13'd2048);
    random_burst(80, 78, 0, 1'b0, 1'b1);

    // Narrowest atlas, receiver stalling.
    reconfigure(13'd1, 13'd3000);
    random_burst(70, 0, 78, 1'b0, 1'b0);

    reconfigure(13'd1000, 13'd4096);
    random_burst(100, 12, 12, 1'b0, 1'b0);

    // Lowest atlas: only already open shelves can take anything.
    reconfigure(13'd4096, 13'd1);
    random_burst(20, 0, 0, 1'b0, 1'b0);

    // Widest register values: sweep the classes to wrap coordinates and saturate the area.
    reconfigure(13'd8191, 13'd8191);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int k = 12; k >= 1; k--) begin
      if (k >= 10) begin
        send_rect(13'd4096, DIM_W'(1 << k));
        send_rect(13'd4095, DIM_W'(1 << k));
      end else begin
        send_rect(13'd8191, DIM_W'(1 << k));
      end
    end
    random_burst(40, 0, 0, 1'b0, 1'b0);

    settle();
    $display("Run covered %0d requests: %0d placed, %0d refused, over seven atlas settings,",
             board.placed_cnt + board.refused_cnt, board.placed_cnt, board.refused_cnt);
    $display("with back-to-back, sparse, stalled, mixed and long hold-off traffic.");
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
